// ===== rtl/core/lspfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lspfs_pkg
// Shared types, codes and field widths of the LED strip frame sequencer.
// ----------------------------------------------------------------------------
package lspfs_pkg;

    localparam int MAX_LEDS_DEF       = 128;
    localparam int SLOTS_PER_HALF_DEF = 16;

    localparam int MODE_W     = 2;
    localparam int INDEX_W    = 7;
    localparam int COLOR_W    = 8;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 5;
    localparam int ONE_CMP_W  = 16;
    localparam int ZERO_CMP_W = 14;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [7:0]  BRIGHTNESS_RST  = 8'd255;
    localparam logic [16:0] BIT_PERIOD_RST  = 17'd80;
    localparam logic [10:0] PRE_RESET_RST   = 11'd10;
    localparam logic [10:0] POST_RESET_RST  = 11'd8;
    localparam logic [7:0]  ACTIVE_LEDS_RST = 8'd128;

    localparam logic [16:0] BIT_PERIOD_MIN = 17'd4;
    localparam logic [16:0] BIT_PERIOD_MAX = 17'd65536;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_HALF0 = 2'd1,
        MODE_HALF1 = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SLOT     = 2'd0,
        KIND_REFUSED  = 2'd1,
        KIND_FINISHED = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_BRIGHTNESS  = 3'd0,
        REG_BIT_PERIOD  = 3'd1,
        REG_PRE_RESET   = 3'd2,
        REG_POST_RESET  = 3'd3,
        REG_ACTIVE_LEDS = 3'd4
    } reg_index_t;

    // Control that travels with one result through the colour pipeline.
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              zero_slot;
        logic              last;
    } slot_ctl_t;

endpackage

// ===== rtl/core/lspfs_if.sv =====
// ----------------------------------------------------------------------------
// lspfs_if
// Valid/ready channels for requests into and results out of the sequencer.
// ----------------------------------------------------------------------------
interface lspfs_in_if import lspfs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;

    modport source (output valid, mode, led_index, red_in, green_in, blue_in, input ready);
    modport sink (input valid, mode, led_index, red_in, green_in, blue_in, output ready);
endinterface

interface lspfs_out_if import lspfs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [SLOT_W-1:0]     slot;
    logic                  zero_slot;
    logic [COLOR_W-1:0]    green_out;
    logic [COLOR_W-1:0]    red_out;
    logic [COLOR_W-1:0]    blue_out;
    logic [ONE_CMP_W-1:0]  one_compare;
    logic [ZERO_CMP_W-1:0] zero_compare;
    logic                  last;

    modport source (output valid, kind, slot, zero_slot, green_out, red_out, blue_out,
                    one_compare, zero_compare, last, input ready);
    modport sink (input valid, kind, slot, zero_slot, green_out, red_out, blue_out,
                  one_compare, zero_compare, last, output ready);
endinterface

// ===== rtl/core/lspfs_ram.sv =====
// ----------------------------------------------------------------------------
// lspfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lspfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/led_strip_pwm_frame_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// led_strip_pwm_frame_sequencer_top
// Fills a double-buffered compare store for a one-wire RGB LED strip.
// ----------------------------------------------------------------------------
// Colour writes give no result. A start request is planned in the ST_SETUP
// state and then issues 2*SLOTS_PER_HALF slot results, one per cycle while
// the output is not stalled; a half-sent event issues up to SLOTS_PER_HALF
// results the same way, and a refused start or a frame stop gives a single
// result. The input is taken again as soon as the last slot of a request has
// been issued, so requests are handled one at a time by the single slot
// sequencer and the one read port of the colour memory. Each result passes
// the registered stages memory read, colour multiply and divide by 255 after
// it is issued, and the pipeline stalls as a whole while the output waits.
// The colour memory needs no clearing after reset: every LED must be written
// before a frame is started.
module led_strip_pwm_frame_sequencer_top
    import lspfs_pkg::*;
#(
    parameter int MAX_LEDS       = MAX_LEDS_DEF,
    parameter int SLOTS_PER_HALF = SLOTS_PER_HALF_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    lspfs_in_if.sink           items,
    lspfs_out_if.source        results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int LA_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int OFF_W  = $clog2(2 * SLOTS_PER_HALF + 1);
    localparam int CALC_W = 18;
    localparam logic [CALC_W-1:0] S_C        = CALC_W'(SLOTS_PER_HALF);
    localparam logic [CALC_W-1:0] S2_C       = CALC_W'(2 * SLOTS_PER_HALF);
    localparam logic [CALC_W-1:0] MAX_LEDS_C = CALC_W'(MAX_LEDS);
    localparam logic [15:0]       S_CNT      = 16'(SLOTS_PER_HALF);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [7:0]  brightness_reg;
    logic [16:0] bit_period_reg;
    logic [10:0] pre_reset_reg;
    logic [10:0] post_reset_reg;
    logic [7:0]  active_leds_reg;
    logic        cfg_write;
    reg_index_t  cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= BRIGHTNESS_RST;
            bit_period_reg  <= BIT_PERIOD_RST;
            pre_reset_reg   <= PRE_RESET_RST;
            post_reset_reg  <= POST_RESET_RST;
            active_leds_reg <= ACTIVE_LEDS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_BRIGHTNESS:  brightness_reg  <= pwdata[7:0];
                REG_BIT_PERIOD:  bit_period_reg  <= pwdata[16:0];
                REG_PRE_RESET:   pre_reset_reg   <= pwdata[10:0];
                REG_POST_RESET:  post_reset_reg  <= pwdata[10:0];
                REG_ACTIVE_LEDS: active_leds_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_BRIGHTNESS:  prdata = PDATA_W'(brightness_reg);
            REG_BIT_PERIOD:  prdata = PDATA_W'(bit_period_reg);
            REG_PRE_RESET:   prdata = PDATA_W'(pre_reset_reg);
            REG_POST_RESET:  prdata = PDATA_W'(post_reset_reg);
            REG_ACTIVE_LEDS: prdata = PDATA_W'(active_leds_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Compare words from the clamped bit period
    // ------------------------------------------------------------------------
    logic [16:0]           period_cl;
    logic [17:0]           period_x3;
    logic [ONE_CMP_W-1:0]  one_cmp;
    logic [ZERO_CMP_W-1:0] zero_cmp;

    always_comb
    begin
        if (bit_period_reg < BIT_PERIOD_MIN)
        begin
            period_cl = BIT_PERIOD_MIN;
        end
        else if (bit_period_reg > BIT_PERIOD_MAX)
        begin
            period_cl = BIT_PERIOD_MAX;
        end
        else
        begin
            period_cl = bit_period_reg;
        end
        period_x3 = {1'b0, period_cl} + {period_cl, 1'b0};
        one_cmp   = ONE_CMP_W'((period_x3 >> 2) - 18'd1);
        zero_cmp  = ZERO_CMP_W'((period_cl >> 2) - 17'd1);
    end

    // ------------------------------------------------------------------------
    // Request intake and slot sequencer
    // ------------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic             busy_reg, busy_next;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      cnext_reg;
    mode_t            mode_reg;
    kind_t            kind_reg, plan_kind;
    logic             half_reg, plan_half;
    logic [OFF_W-1:0] off_reg, off_next, plan_begin;
    logic [OFF_W-1:0] end_reg, plan_end;
    logic [OFF_W-1:0] lo_reg, plan_lo;
    logic [OFF_W-1:0] hi_reg, plan_hi;
    logic [LA_W-1:0]  led_reg, led_next, plan_led;

    logic             accept;
    mode_t            in_mode;
    logic             advance;
    logic             is_led;
    logic             run_last;
    logic [OFF_W:0]   slot_full;
    slot_ctl_t        a_ctl;

    logic [CALC_W-1:0] pre18, post18, n18, pn18, c18, span18, d18;

    assign in_mode     = mode_t'(items.mode);
    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid & items.ready;

    // Frame plan: which offsets of a half are written and which carry LEDs.
    always_comb
    begin
        pre18      = CALC_W'(pre_reset_reg);
        post18     = CALC_W'(post_reset_reg);
        n18        = (CALC_W'(active_leds_reg) > MAX_LEDS_C) ? MAX_LEDS_C
                                                             : CALC_W'(active_leds_reg);
        pn18       = pre18 + n18;
        c18        = CALC_W'(cnext_reg);
        span18     = '0;
        d18        = '0;
        busy_next  = busy_reg;
        count_next = count_reg;
        plan_kind  = KIND_SLOT;
        plan_half  = (mode_reg == MODE_HALF1);
        plan_begin = '0;
        plan_end   = '0;
        plan_lo    = '0;
        plan_hi    = '0;
        plan_led   = '0;
        case (mode_reg)
            MODE_START:
            begin
                if (busy_reg)
                begin
                    plan_kind = KIND_REFUSED;
                    plan_end  = OFF_W'(1);
                end
                else
                begin
                    busy_next  = 1'b1;
                    count_next = S_CNT;
                    plan_end   = OFF_W'(S2_C);
                    plan_lo    = OFF_W'((pre18 > S2_C) ? S2_C : pre18);
                    plan_hi    = OFF_W'((pn18 > S2_C) ? S2_C : pn18);
                end
            end
            MODE_HALF0, MODE_HALF1:
            begin
                if (busy_reg)
                begin
                    count_next = cnext_reg;
                    if (c18 < pre18)
                    begin
                        // Still in the leading zeros: only the half where the
                        // first LEDs begin is written.
                        if (c18 + S_C > pre18)
                        begin
                            d18        = pre18 - c18;
                            span18     = d18 + n18;
                            plan_begin = OFF_W'(d18);
                            plan_lo    = OFF_W'(d18);
                            plan_hi    = OFF_W'((span18 > S_C) ? S_C : span18);
                            plan_end   = OFF_W'((span18 > S_C) ? S_C : span18);
                        end
                    end
                    else if (c18 < pn18)
                    begin
                        span18   = pn18 - c18;
                        plan_end = OFF_W'(S_C);
                        plan_hi  = OFF_W'((span18 > S_C) ? S_C : span18);
                        plan_led = LA_W'(c18 - pre18);
                    end
                    else if (c18 < pn18 + post18 + S_C)
                    begin
                        // A half needs zeroing at most twice after the data.
                        if (c18 < pn18 + S2_C)
                        begin
                            plan_end = OFF_W'(S_C);
                        end
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        plan_kind = KIND_FINISHED;
                        plan_end  = OFF_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign is_led    = (off_reg >= lo_reg) && (off_reg < hi_reg);
    assign run_last  = (off_reg + OFF_W'(1)) == end_reg;
    assign slot_full = {1'b0, off_reg} + (half_reg ? (OFF_W + 1)'(SLOTS_PER_HALF)
                                                   : (OFF_W + 1)'(0));

    always_comb
    begin
        a_ctl.kind      = kind_reg;
        a_ctl.slot      = (kind_reg == KIND_SLOT) ? SLOT_W'(slot_full) : '0;
        a_ctl.zero_slot = (kind_reg == KIND_SLOT) && !is_led;
        a_ctl.last      = run_last;
    end

    always_comb
    begin
        state_next = state_reg;
        off_next   = off_reg;
        led_next   = led_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_mode != MODE_WRITE)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                off_next   = plan_begin;
                led_next   = plan_led;
                state_next = (plan_end > plan_begin) ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    off_next = off_reg + OFF_W'(1);
                    led_next = led_reg + LA_W'(is_led);
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SETUP)
            begin
                busy_reg  <= busy_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        led_reg <= led_next;
        if (accept)
        begin
            mode_reg  <= in_mode;
            cnext_reg <= count_reg + S_CNT;
        end
        if (state_reg == ST_SETUP)
        begin
            kind_reg <= plan_kind;
            half_reg <= plan_half;
            end_reg  <= plan_end;
            lo_reg   <= plan_lo;
            hi_reg   <= plan_hi;
        end
    end

    // ------------------------------------------------------------------------
    // Colour store
    // ------------------------------------------------------------------------
    logic        ram_wr_en;
    logic        ram_rd_en;
    logic [23:0] ram_rd_data;

    assign ram_wr_en = accept && (in_mode == MODE_WRITE) &&
                       (CALC_W'(items.led_index) < MAX_LEDS_C);
    assign ram_rd_en = advance && (state_reg == ST_RUN) && is_led;

    lspfs_ram #(
        .WIDTH (24),
        .DEPTH (MAX_LEDS),
        .ADDR_W(LA_W)
    ) u_colour_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(LA_W'(items.led_index)),
        .wr_data({items.red_in, items.green_in, items.blue_in}),
        .rd_en  (ram_rd_en),
        .rd_addr(led_reg),
        .rd_data(ram_rd_data)
    );

    // ------------------------------------------------------------------------
    // Colour pipeline: read, multiply by brightness, divide by 255
    // ------------------------------------------------------------------------
    logic        p1_valid_reg, p2_valid_reg, out_valid_reg;
    slot_ctl_t   p1_ctl_reg, p2_ctl_reg, out_ctl_reg;
    logic [15:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [7:0]  out_r_reg, out_g_reg, out_b_reg;
    logic [ONE_CMP_W-1:0]  out_one_reg;
    logic [ZERO_CMP_W-1:0] out_zero_reg;
    logic        p2_led;

    assign advance = !out_valid_reg || results.ready;
    assign p2_led  = (p2_ctl_reg.kind == KIND_SLOT) && !p2_ctl_reg.zero_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg  <= (state_reg == ST_RUN);
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_ctl_reg   <= a_ctl;
            p2_ctl_reg   <= p1_ctl_reg;
            prod_r_reg   <= ram_rd_data[23:16] * brightness_reg;
            prod_g_reg   <= ram_rd_data[15:8] * brightness_reg;
            prod_b_reg   <= ram_rd_data[7:0] * brightness_reg;
            out_ctl_reg  <= p2_ctl_reg;
            out_r_reg    <= p2_led ? div255(prod_r_reg) : '0;
            out_g_reg    <= p2_led ? div255(prod_g_reg) : '0;
            out_b_reg    <= p2_led ? div255(prod_b_reg) : '0;
            out_one_reg  <= p2_led ? one_cmp : '0;
            out_zero_reg <= p2_led ? zero_cmp : '0;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = out_ctl_reg.kind;
    assign results.slot         = out_ctl_reg.slot;
    assign results.zero_slot    = out_ctl_reg.zero_slot;
    assign results.green_out    = out_g_reg;
    assign results.red_out      = out_r_reg;
    assign results.blue_out     = out_b_reg;
    assign results.one_compare  = out_one_reg;
    assign results.zero_compare = out_zero_reg;
    assign results.last         = out_ctl_reg.last;

endmodule
